FILE: rtl/v2u_pkg.sv
// v2u_pkg: types and constants for the v210 to 8-bit UYVY unpacker
// no dependencies; used by v210_to_uyvy8_unpacker
`default_nettype none

package v2u_pkg;

	// configuration register width and register indexes
	localparam int CFG_W = 14;
	localparam int IDX_W = 1;
	localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = 1'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 14'd1920;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 14'd1080;

	localparam int LINE_W    = 14;
	localparam int SAMPLE_W  = 8;
	localparam int COMP_W    = 2;
	localparam int SMP_BITS  = 10;
	localparam int SMP_DROP  = 2;
	localparam int SMP_PER_WORD = 3;
	localparam int WORD_W_IN = 32;

	// line padding: 48 luma samples take 32 words
	localparam int LUMA_PER_BLOCK = 48;
	localparam int WORDS_PER_BLOCK = 32;
	localparam int BLK_SH  = 5;
	localparam int GRP_SH  = 4;
	localparam int GRP_W   = CFG_W + 1 - GRP_SH;
	localparam int BLK_W   = 9;
	localparam int LASTW_W = BLK_W + BLK_SH;

	// ceil(x/3) for x up to a few thousand: ((x + 2) * RECIP3) >> RECIP_SH
	localparam int RECIP_SH = 16;
	localparam int PROD_W   = GRP_W + 1 + RECIP_SH;
	localparam logic [RECIP_SH-1:0] RECIP3 = 16'd21846;

	typedef enum logic [COMP_W-1:0] {
		COMP_CB = 2'd0,
		COMP_Y  = 2'd1,
		COMP_CR = 2'd2
	} comp_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] smp;
		comp_t               comp;
		logic                last;
		logic                eol;
		logic                eof;
	} item_t;

	// sample order along a line is Cb Y Cr Y
	function automatic comp_t comp_of(input logic [1:0] phase);
		comp_t c;
		case (phase)
			2'd0: c = COMP_CB;
			2'd1: c = COMP_Y;
			2'd2: c = COMP_CR;
			2'd3: c = COMP_Y;
			default: c = COMP_Y;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/v210_to_uyvy8_unpacker.sv
// v210 to 8-bit UYVY unpacker, top level
// depends on v2u_pkg
`default_nettype none

// Takes one 32-bit v210 word per item and emits its active 10-bit samples as
// 8-bit samples (top bits, truncated), one sample per result, in Cb Y Cr Y
// order, with end of line and end of frame marks. A word that gives no sample
// or one sample lets the next word follow back to back while the output is not
// stalled; a word that gives more holds the input while the single-sample
// result register drains a three-entry holding stage, one sample per cycle
// when the output is not stalled. Padding words at the end of each line
// (lines are padded to 48 luma samples per 32 words) take no place in the
// holding stage and give nothing. Configuration writes take effect on the
// next word.
module v210_to_uyvy8_unpacker #(
	parameter int MAX_WIDTH = 8192
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [v2u_pkg::IDX_W-1:0]          cfg_index,
	input  wire  [v2u_pkg::CFG_W-1:0]          cfg_data,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [v2u_pkg::WORD_W_IN-1:0]      packed_word,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [v2u_pkg::SAMPLE_W-1:0]       sample,
	output logic [v2u_pkg::COMP_W-1:0]         component,
	output logic                               last_of_run,
	output logic                               end_of_line,
	output logic                               end_of_frame
);

	localparam int CFG_MAX  = (1 << v2u_pkg::CFG_W) - 1;
	localparam int MAX_EFF  = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
	localparam int MAX_WPL  = ((MAX_EFF + v2u_pkg::LUMA_PER_BLOCK - 1) /
		v2u_pkg::LUMA_PER_BLOCK) * v2u_pkg::WORDS_PER_BLOCK;
	localparam int WORD_W   = $clog2(MAX_WPL);
	localparam int SAMP_W   = $clog2(v2u_pkg::SMP_PER_WORD * MAX_WPL + 1);
	localparam int LW_EXT_W = v2u_pkg::CFG_W + 1;
	localparam int NSMP     = v2u_pkg::SMP_PER_WORD;

	logic [v2u_pkg::CFG_W-1:0]  line_width_q;
	logic [v2u_pkg::CFG_W-1:0]  frame_height_q;
	logic [WORD_W-1:0]          word_q;
	logic [SAMP_W-1:0]          samp_q;
	logic [v2u_pkg::LINE_W-1:0] line_q;

	v2u_pkg::item_t             ent_s1 [NSMP];
	logic [1:0]                 cnt_s1;
	v2u_pkg::item_t             out_s2;
	logic                       out_valid_q;

	logic [v2u_pkg::CFG_W-1:0]   eff_w;
	logic [v2u_pkg::CFG_W:0]     grp_sum;
	logic [v2u_pkg::GRP_W:0]     grp_p2;
	logic [v2u_pkg::PROD_W-1:0]  prod;
	logic [v2u_pkg::BLK_W-1:0]   blocks;
	logic [v2u_pkg::BLK_W-1:0]   blocks_eff;
	logic [v2u_pkg::LASTW_W-1:0] last_word;
	logic                        word_end;
	logic [SAMP_W-1:0]           active;
	logic [v2u_pkg::CFG_W-1:0]   eff_h;
	logic                        last_line;
	logic [NSMP:0]               act;
	v2u_pkg::item_t              new_ent [NSMP];
	logic [1:0]                  n_new;
	logic                        emit;
	logic                        accept;

	// padded line length in words, from the saturated width
	always_comb begin
		if ({1'b0, line_width_q} > LW_EXT_W'(MAX_WIDTH)) begin
			eff_w = v2u_pkg::CFG_W'(MAX_WIDTH);
		end else begin
			eff_w = line_width_q;
		end
		grp_sum    = {1'b0, eff_w} + LW_EXT_W'(15);
		grp_p2     = {1'b0, grp_sum[v2u_pkg::CFG_W:v2u_pkg::GRP_SH]} + (v2u_pkg::GRP_W + 1)'(2);
		prod       = v2u_pkg::PROD_W'(grp_p2) * v2u_pkg::PROD_W'(v2u_pkg::RECIP3);
		blocks     = prod[v2u_pkg::RECIP_SH +: v2u_pkg::BLK_W];
		blocks_eff = (blocks == '0) ? v2u_pkg::BLK_W'(1) : blocks;
		last_word  = {blocks_eff - v2u_pkg::BLK_W'(1), {v2u_pkg::BLK_SH{1'b1}}};
		word_end   = v2u_pkg::LASTW_W'(word_q) >= last_word;
		active     = SAMP_W'({eff_w, 1'b0});
	end

	always_comb begin
		eff_h     = (frame_height_q == '0) ? v2u_pkg::CFG_W'(1) : frame_height_q;
		last_line = ({1'b0, line_q} + (v2u_pkg::LINE_W + 1)'(1)) >= {1'b0, eff_h};
	end

	// the three samples of the incoming word; active ones form a prefix
	always_comb begin
		logic [SAMP_W-1:0] s;
		act[NSMP] = 1'b0;
		for (int k = 0; k < NSMP; k++) begin
			s = samp_q + SAMP_W'(k);
			act[k] = s < active;
			new_ent[k].smp  = packed_word[v2u_pkg::SMP_BITS*k + v2u_pkg::SMP_DROP +:
				v2u_pkg::SAMPLE_W];
			new_ent[k].comp = v2u_pkg::comp_of(s[1:0]);
			new_ent[k].eol  = (s + SAMP_W'(1)) == active;
			new_ent[k].eof  = ((s + SAMP_W'(1)) == active) && last_line;
		end
		for (int k = 0; k < NSMP; k++) begin
			new_ent[k].last = act[k] && !act[k+1];
		end
		n_new = 2'(act[0]) + 2'(act[1]) + 2'(act[2]);
	end

	assign emit     = (cnt_s1 != 2'd0) && (!out_valid_q || out_ready);
	assign in_ready = (cnt_s1 == 2'd0) || ((cnt_s1 == 2'd1) && emit);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= v2u_pkg::LINE_WIDTH_RST;
			frame_height_q <= v2u_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				v2u_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data;
				v2u_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position counters advance once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			samp_q <= '0;
			line_q <= '0;
		end else if (accept) begin
			if (word_end) begin
				word_q <= '0;
				samp_q <= '0;
				line_q <= last_line ? '0 : line_q + v2u_pkg::LINE_W'(1);
			end else begin
				word_q <= word_q + WORD_W'(1);
				samp_q <= samp_q + SAMP_W'(NSMP);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_s1 <= n_new;
			end else if (emit) begin
				cnt_s1 <= cnt_s1 - 2'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// holding stage shifts down as samples leave
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < NSMP; k++) begin
				ent_s1[k] <= new_ent[k];
			end
		end else if (emit) begin
			for (int k = 0; k < NSMP - 1; k++) begin
				ent_s1[k] <= ent_s1[k+1];
			end
		end
		if (emit) begin
			out_s2 <= ent_s1[0];
		end
	end

	assign out_valid    = out_valid_q;
	assign sample       = out_s2.smp;
	assign component    = out_s2.comp;
	assign last_of_run  = out_s2.last;
	assign end_of_line  = out_s2.eol;
	assign end_of_frame = out_s2.eof;

`ifndef NO_ASSERTIONS
	a_eof_is_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> end_of_line)
		else $error("end of frame without end of line");

	a_eol_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_line |-> last_of_run)
		else $error("end of line not last sample of its word");

	a_samp_tracks_word: assert property (@(posedge clk) disable iff (!arst_n)
		32'(samp_q) == 32'(word_q) * NSMP)
		else $error("sample counter out of step with word counter");

	a_word_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(word_q) < MAX_WPL)
		else $error("word counter past padded line");

	a_line_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(line_q != $past(line_q)) |-> (word_q == '0))
		else $error("line counter moved mid-line");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// testbench for v210_to_uyvy8_unpacker: drives v210 words, predicts the 8-bit samples
// and their line and frame marks, and checks every result item in order
// depends on v2u_pkg and rtl/v210_to_uyvy8_unpacker.sv
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_WIDTH   = 8192;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 8;

	typedef struct {
		logic [v2u_pkg::SAMPLE_W-1:0] smp;
		v2u_pkg::comp_t               comp;
		logic                         last;
		logic                         eol;
		logic                         eof;
	} uyvy_smp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [v2u_pkg::IDX_W-1:0] cfg_index;
	logic [v2u_pkg::CFG_W-1:0] cfg_data;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [v2u_pkg::WORD_W_IN-1:0] packed_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [v2u_pkg::SAMPLE_W-1:0] sample;
	logic [v2u_pkg::COMP_W-1:0] component;
	logic last_of_run;
	logic end_of_line;
	logic end_of_frame;

	v210_to_uyvy8_unpacker #(.MAX_WIDTH(MAX_WIDTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packed_word  (packed_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample       (sample),
		.component    (component),
		.last_of_run  (last_of_run),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame)
	);

	// pending words and expected samples
	logic [v2u_pkg::WORD_W_IN-1:0] word_queue[$];
	uyvy_smp_t expected_samples[$];

	// shadow of the configuration and the line position counters
	logic [v2u_pkg::CFG_W-1:0] cfg_line_width = v2u_pkg::LINE_WIDTH_RST;
	logic [v2u_pkg::CFG_W-1:0] cfg_frame_height = v2u_pkg::FRAME_HEIGHT_RST;
	logic [12:0] word_pos = '0;
	logic [14:0] smp_pos = '0;
	logic [13:0] line_pos = '0;

	int mismatches = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_taken = 1'b0;
	bit hold_req = 1'b0;
	bit steady = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void predict_samples(input logic [v2u_pkg::WORD_W_IN-1:0] w);
		int unsigned eff_w, active, hgt, blocks, wpl, s;
		bit last_line;
		uyvy_smp_t r;
		eff_w = (cfg_line_width > MAX_WIDTH) ? MAX_WIDTH : cfg_line_width;
		active = 2 * eff_w;
		hgt = (cfg_frame_height == 0) ? 1 : cfg_frame_height;
		last_line = (line_pos + 1) >= hgt;
		for (int k = 0; k < v2u_pkg::SMP_PER_WORD; k++) begin
			s = smp_pos + k;
			if (s < active) begin
				r.smp  = w[10*k+2 +: 8];
				// line order is Cb Y Cr Y
				r.comp = s[0] ? v2u_pkg::COMP_Y :
					(s[1] ? v2u_pkg::COMP_CR : v2u_pkg::COMP_CB);
				r.last = (k == v2u_pkg::SMP_PER_WORD - 1) || (s + 1 >= active);
				r.eol  = (s + 1 == active);
				r.eof  = r.eol && last_line;
				expected_samples.push_back(r);
			end
		end
		// padded line: 32 words per 48 luma samples, at least one block
		blocks = (eff_w + 47) / 48;
		if (blocks == 0)
			blocks = 1;
		wpl = blocks * 32;
		if (word_pos + 1 >= wpl) begin
			word_pos = '0;
			smp_pos = '0;
			line_pos = last_line ? 14'd0 : line_pos + 14'd1;
		end else begin
			word_pos = word_pos + 13'd1;
			smp_pos = 15'(word_pos * 3);
		end
	endfunction

	// word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			packed_word <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_samples(packed_word);
			if (!in_valid || in_ready) begin
				if (word_queue.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
					in_valid <= 1'b1;
					packed_word <= word_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 30);
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		uyvy_smp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item, expected none, actual sample %0h component %0d",
					$time, sample, component);
			end else begin
				e = expected_samples.pop_front();
				check_field("sample", e.smp, sample);
				check_field("component", e.comp, component);
				check_field("last_of_run", e.last, last_of_run);
				check_field("end_of_line", e.eol, end_of_line);
				check_field("end_of_frame", e.eof, end_of_frame);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("v210_to_uyvy8_unpacker regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_random(input int n);
		@(negedge clk);
		repeat (n) word_queue.push_back($urandom());
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (word_queue.size() != 0 || in_valid || expected_samples.size() != 0);
		// a padding word may still be in flight
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [v2u_pkg::IDX_W-1:0] idx,
		input logic [v2u_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == v2u_pkg::REG_LINE_WIDTH)
			cfg_line_width = val;
		else
			cfg_frame_height = val;
	endtask

	task automatic reconfigure(input logic [v2u_pkg::CFG_W-1:0] lw,
		input logic [v2u_pkg::CFG_W-1:0] fh);
		wait_drained();
		write_reg(v2u_pkg::REG_LINE_WIDTH, lw);
		write_reg(v2u_pkg::REG_FRAME_HEIGHT, fh);
	endtask

	initial begin
		int random_words;
		int n;
		logic [v2u_pkg::CFG_W-1:0] next_width, next_height;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = v2u_pkg::REG_LINE_WIDTH;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: extremes of the word, low bits only, unused top bits only, kept bits only
		@(negedge clk);
		word_queue.push_back(32'h0000_0000);
		word_queue.push_back(32'hffff_ffff);
		word_queue.push_back(32'h0030_0c03);
		word_queue.push_back(32'hc000_0000);
		word_queue.push_back(32'h3fcf_f3fc);

		// odd width, zero height, written mid-line: rest of the line is padding
		reconfigure(14'd3, 14'd0);
		push_random(27);
		@(negedge clk);
		word_queue.push_back(32'h2aaa_aaaa);
		word_queue.push_back(32'h1555_5555);
		push_random(3);

		// zero width: padding words up to the end of the line
		reconfigure(14'd0, 14'd2);
		push_random(27);

		// short width over a whole line, then the frame shortened mid-frame
		reconfigure(14'd6, 14'd3);
		push_random(32);
		wait_drained();
		write_reg(v2u_pkg::REG_FRAME_HEIGHT, 14'd1);
		push_random(8);

		// width above the maximum saturates; a back to back burst with a long stall
		reconfigure(14'h3fff, 14'd1);
		steady = 1'b1;
		push_random(24);
		@(negedge clk);
		hold_req = 1'b1;
		wait_drained();
		steady = 1'b0;

		random_words = 0;
		while (random_words < 40) begin
			case ($urandom_range(7))
				0: next_width = $urandom_range(1) ? 14'd8192 : 14'h3fff;
				1: next_width = v2u_pkg::CFG_W'($urandom_range(1, 3));
				default: next_width = v2u_pkg::CFG_W'($urandom_range(0, 100));
			endcase
			if ($urandom_range(3) == 0)
				next_height = $urandom_range(1) ? 14'd8192 : 14'h3fff;
			else
				next_height = v2u_pkg::CFG_W'($urandom_range(0, 4));
			reconfigure(next_width, next_height);
			steady = ($urandom_range(3) == 0);
			n = int'($urandom_range(1, 16));
			push_random(n);
			random_words += n;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("v210_to_uyvy8_unpacker regression: pass");
		else
			$display("v210_to_uyvy8_unpacker regression: fail");
		$finish;
	end

endmodule
